// File: rtl/cpt_pkg.sv
// Shared types, constants and helper functions of the cascaded prescaled timer bank.
package cpt_pkg;

    // Number of timers present (1 to 4). Ports always carry four counters.
    localparam int CPT_NUM_TIMERS = 4;
    localparam int CPT_IDX_W      = (CPT_NUM_TIMERS > 1) ? $clog2(CPT_NUM_TIMERS) : 1;
    localparam logic [CPT_IDX_W-1:0] CPT_LAST_IDX = CPT_IDX_W'(CPT_NUM_TIMERS - 1);

    localparam int CPT_CNT_W   = 16;
    localparam int CPT_ACC_W   = 11;
    localparam int CPT_CYC_W   = 8;
    localparam int CPT_POP_W   = 8;
    localparam int CPT_CTL_W   = 32;
    localparam int CPT_CFG_IDX_W = 3;

    // Bits of a timer control byte.
    localparam int CPT_CTL_COUNTUP = 2;
    localparam int CPT_CTL_IRQ_EN  = 6;
    localparam int CPT_CTL_ENABLE  = 7;
    localparam logic [7:0] CPT_CTL_CASCADE_ON = 8'h84;

    // Largest prescale period; the accumulator always falls below it when idle.
    localparam logic [CPT_ACC_W-1:0] CPT_MAX_PERIOD = 11'd1024;

    // Configuration register indexes.
    typedef enum logic [CPT_CFG_IDX_W-1:0] {
        CPT_REG_CTL      = 3'd0,
        CPT_REG_RELOAD0  = 3'd1,
        CPT_REG_RELOAD1  = 3'd2,
        CPT_REG_RELOAD2  = 3'd3,
        CPT_REG_RELOAD3  = 3'd4,
        CPT_REG_FIFO_SEL = 3'd5
    } t_cpt_reg;

    // Prescaler select codes.
    typedef enum logic [1:0] {
        CPT_PRE_1    = 2'd0,
        CPT_PRE_64   = 2'd1,
        CPT_PRE_256  = 2'd2,
        CPT_PRE_1024 = 2'd3
    } t_cpt_pre;

    // Commands from the sequencer to the timer unit.
    typedef struct packed {
        logic                 start;
        logic                 add;
        logic                 sub;
        logic                 tick;
        logic                 finish;
        logic [CPT_IDX_W-1:0] base;
        logic [CPT_IDX_W-1:0] cur;
    } t_cpt_cmd;

    // Status from the timer unit back to the sequencer.
    typedef struct packed {
        logic active;
        logic drain_more;
        logic cascade;
    } t_cpt_stat;

    // One finished result.
    typedef struct packed {
        logic [3:0]                irq_mask;
        logic [CPT_POP_W-1:0]      pops_a;
        logic [CPT_POP_W-1:0]      pops_b;
        logic [3:0][CPT_CNT_W-1:0] count;
    } t_cpt_res;

    function automatic logic [CPT_ACC_W-1:0] cpt_period(input logic [1:0] sel);
        logic [CPT_ACC_W-1:0] p;
        case (t_cpt_pre'(sel))
            CPT_PRE_1:    p = 11'd1;
            CPT_PRE_64:   p = 11'd64;
            CPT_PRE_256:  p = 11'd256;
            CPT_PRE_1024: p = 11'd1024;
            default:      p = 11'd1;
        endcase
        return p;
    endfunction

endpackage

// File: rtl/cpt_if.sv
// Valid/ready stream interfaces for the input items and result items of the timer bank.
interface cpt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] elapsed_cycles;

    modport source (output valid, output elapsed_cycles, input ready);
    modport sink   (input valid, input elapsed_cycles, output ready);
endinterface

interface cpt_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  irq_mask;
    logic [7:0]  fifo_a_pops;
    logic [7:0]  fifo_b_pops;
    logic [15:0] count0;
    logic [15:0] count1;
    logic [15:0] count2;
    logic [15:0] count3;

    modport source (output valid, output irq_mask, output fifo_a_pops, output fifo_b_pops,
                    output count0, output count1, output count2, output count3,
                    input ready);
    modport sink   (input valid, input irq_mask, input fifo_a_pops, input fifo_b_pops,
                    input count0, input count1, input count2, input count3,
                    output ready);
endinterface

// File: rtl/cpt_unit.sv
// Timer state and the shared accumulate, compare and increment unit.
module cpt_unit (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic [cpt_pkg::CPT_CTL_W-1:0]             i_ctl,
    input  logic [3:0][cpt_pkg::CPT_CNT_W-1:0]        i_reload,
    input  logic [1:0]                                i_fifo_sel,
    input  logic [cpt_pkg::CPT_CYC_W-1:0]             i_cycles,
    input  cpt_pkg::t_cpt_cmd                         i_cmd,
    output cpt_pkg::t_cpt_stat                        o_stat,
    output cpt_pkg::t_cpt_res                         o_res
);

    logic [cpt_pkg::CPT_NUM_TIMERS-1:0][cpt_pkg::CPT_CNT_W-1:0] r_count;
    logic [cpt_pkg::CPT_NUM_TIMERS-1:0][cpt_pkg::CPT_ACC_W-1:0] r_accum;
    logic [cpt_pkg::CPT_CYC_W-1:0] r_cycles;
    logic [3:0]                    r_irq;
    logic [cpt_pkg::CPT_POP_W-1:0] r_pops_a;
    logic [cpt_pkg::CPT_POP_W-1:0] r_pops_b;

    logic [7:0]                    ctl_base;
    logic [7:0]                    ctl_cur;
    logic [7:0]                    ctl_nxt;
    logic [cpt_pkg::CPT_IDX_W-1:0] nxt_idx;
    logic [cpt_pkg::CPT_ACC_W-1:0] period;
    logic [cpt_pkg::CPT_ACC_W-1:0] acc_base;
    logic [cpt_pkg::CPT_CNT_W-1:0] cnt_cur;
    logic                          ovf;
    logic                          feeds_a;
    logic                          feeds_b;

    assign nxt_idx  = i_cmd.cur + 1'b1;
    assign ctl_base = i_ctl[8 * 32'(i_cmd.base) +: 8];
    assign ctl_cur  = i_ctl[8 * 32'(i_cmd.cur) +: 8];
    assign ctl_nxt  = i_ctl[8 * 32'(nxt_idx) +: 8];
    assign period   = cpt_pkg::cpt_period(ctl_base[1:0]);
    assign acc_base = r_accum[i_cmd.base];
    assign cnt_cur  = r_count[i_cmd.cur];
    assign ovf      = (cnt_cur == '1);

    // Only timers 0 and 1 can feed the sound FIFOs.
    assign feeds_a = (32'(i_cmd.cur) < 2) && (i_fifo_sel[0] == i_cmd.cur[0]);
    assign feeds_b = (32'(i_cmd.cur) < 2) && (i_fifo_sel[1] == i_cmd.cur[0]);

    assign o_stat.active     = ctl_base[cpt_pkg::CPT_CTL_ENABLE] &&
                               !(ctl_base[cpt_pkg::CPT_CTL_COUNTUP] && (i_cmd.base != '0));
    assign o_stat.drain_more = (acc_base >= period);
    assign o_stat.cascade    = ovf && (i_cmd.cur != cpt_pkg::CPT_LAST_IDX) &&
                               ((ctl_nxt & cpt_pkg::CPT_CTL_CASCADE_ON) ==
                                cpt_pkg::CPT_CTL_CASCADE_ON);

    // The cycle count of the item is used from the latched copy once work starts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_accum <= '0;
        end else begin
            if (i_cmd.add) begin
                r_accum[i_cmd.base] <= acc_base + cpt_pkg::CPT_ACC_W'(r_cycles);
            end else if (i_cmd.sub) begin
                r_accum[i_cmd.base] <= acc_base - period;
            end
            if (i_cmd.tick) begin
                r_count[i_cmd.cur] <= ovf ? i_reload[i_cmd.cur] : cnt_cur + 1'b1;
            end
        end
    end

    // Per-item flags and pop counters; cleared when an item is accepted.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cycles <= i_cycles;
            r_irq    <= '0;
            r_pops_a <= '0;
            r_pops_b <= '0;
        end else if (i_cmd.tick && ovf) begin
            if (ctl_cur[cpt_pkg::CPT_CTL_IRQ_EN]) begin
                r_irq[i_cmd.cur] <= 1'b1;
            end
            if (feeds_a && (r_pops_a != '1)) begin
                r_pops_a <= r_pops_a + 1'b1;
            end
            if (feeds_b && (r_pops_b != '1)) begin
                r_pops_b <= r_pops_b + 1'b1;
            end
        end
    end

    always_comb begin
        o_res.irq_mask = r_irq;
        o_res.pops_a   = r_pops_a;
        o_res.pops_b   = r_pops_b;
        for (int i = 0; i < 4; i++) begin
            if (i < cpt_pkg::CPT_NUM_TIMERS) begin
                o_res.count[i] = r_count[i];
            end else begin
                o_res.count[i] = '0;
            end
        end
    end

endmodule

// File: rtl/cpt_seq.sv
// Sequencer that walks the timers and drives the shared unit one tick per cycle while it drains or cascades.
module cpt_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_free,
    input  cpt_pkg::t_cpt_stat  i_stat,
    output logic                o_in_ready,
    output cpt_pkg::t_cpt_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_DRAIN,
        S_CASC,
        S_FINISH
    } t_state;

    t_state                        r_state, n_state;
    logic [cpt_pkg::CPT_IDX_W-1:0] r_base, n_base;
    logic [cpt_pkg::CPT_IDX_W-1:0] r_cur, n_cur;
    logic                          last;

    assign last = (r_base == cpt_pkg::CPT_LAST_IDX);

    always_comb begin
        n_state      = r_state;
        n_base       = r_base;
        n_cur        = r_cur;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        o_cmd.base   = r_base;
        o_cmd.cur    = (r_state == S_CASC) ? r_cur : r_base;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_base      = '0;
                    n_state     = S_ADD;
                end
            end
            S_ADD: begin
                if (i_stat.active) begin
                    o_cmd.add = 1'b1;
                    n_state   = S_DRAIN;
                end else if (last) begin
                    n_state = S_FINISH;
                end else begin
                    n_base = r_base + 1'b1;
                end
            end
            S_DRAIN: begin
                if (i_stat.drain_more) begin
                    o_cmd.sub  = 1'b1;
                    o_cmd.tick = 1'b1;
                    if (i_stat.cascade) begin
                        n_cur   = r_base + 1'b1;
                        n_state = S_CASC;
                    end
                end else if (last) begin
                    n_state = S_FINISH;
                end else begin
                    n_base  = r_base + 1'b1;
                    n_state = S_ADD;
                end
            end
            S_CASC: begin
                o_cmd.tick = 1'b1;
                if (i_stat.cascade) begin
                    n_cur = r_cur + 1'b1;
                end else begin
                    n_state = S_DRAIN;
                end
            end
            S_FINISH: begin
                if (i_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_base  <= '0;
            r_cur   <= '0;
        end else begin
            r_state <= n_state;
            r_base  <= n_base;
            r_cur   <= n_cur;
        end
    end

endmodule

// File: rtl/cascaded_prescaled_timer_bank.sv
// Top level of the four-channel cascaded prescaled timer bank.
//
// A bank of four 16-bit up-counters. Each input item carries an elapsed time count
// since the last one; each enabled timer that is not cascaded adds it to its
// prescale accumulator and ticks once per period of 1, 64, 256 or 1024. On
// overflow a timer reloads, raises its interrupt bit when enabled, counts a sample
// pop for the sound FIFO it feeds, and ticks the timer above it when that timer is
// enabled in count-up mode. One result item per input item reports the interrupt
// mask, both pop counts (saturating at 255) and the four counters. Configuration
// registers are written through a plain write port: index 0 holds the four control
// bytes, 1 to 4 the reload values, 5 the FIFO timer select; other indexes are
// dropped. Work runs on one shared accumulate, compare and increment unit under a
// small sequencer, one timer at a time, and the block takes no new item while it
// works. The shared incrementer makes a single tick per cycle at most, so the work
// on an item grows with the number of timers and with the ticks and cascaded ticks
// of the active timers. The result sits in an output register, so a finished item
// does not hold up the acceptance of the next one; the sequencer only waits at its
// end if the previous result has still not been taken.
module cascaded_prescaled_timer_bank (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    cpt_in_if.sink                             i_in,
    cpt_out_if.source                          o_out,
    input  logic                               i_cfg_we,
    input  logic [cpt_pkg::CPT_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cpt_pkg::CPT_CTL_W-1:0]      i_cfg_wdata
);

    // Configuration registers.
    logic [cpt_pkg::CPT_CTL_W-1:0]      r_ctl;
    logic [3:0][cpt_pkg::CPT_CNT_W-1:0] r_reload;
    logic [1:0]                         r_fifo_sel;

    // Output register.
    logic                               r_out_valid;
    cpt_pkg::t_cpt_res                  r_res;

    cpt_pkg::t_cpt_cmd                  cmd;
    cpt_pkg::t_cpt_stat                 stat;
    cpt_pkg::t_cpt_res                  res;
    logic                               out_free;
    logic                               in_ready;

    // The user must write only while the block is idle; the block does not enforce it, so no guarding is done here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl      <= '0;
            r_reload   <= '0;
            r_fifo_sel <= '0;
        end else if (i_cfg_we) begin
            case (cpt_pkg::t_cpt_reg'(i_cfg_idx))
                cpt_pkg::CPT_REG_CTL:      r_ctl       <= i_cfg_wdata;
                cpt_pkg::CPT_REG_RELOAD0:  r_reload[0] <= i_cfg_wdata[cpt_pkg::CPT_CNT_W-1:0];
                cpt_pkg::CPT_REG_RELOAD1:  r_reload[1] <= i_cfg_wdata[cpt_pkg::CPT_CNT_W-1:0];
                cpt_pkg::CPT_REG_RELOAD2:  r_reload[2] <= i_cfg_wdata[cpt_pkg::CPT_CNT_W-1:0];
                cpt_pkg::CPT_REG_RELOAD3:  r_reload[3] <= i_cfg_wdata[cpt_pkg::CPT_CNT_W-1:0];
                cpt_pkg::CPT_REG_FIFO_SEL: r_fifo_sel  <= i_cfg_wdata[1:0];
                default: begin
                end
            endcase
        end
    end

    // The output register is free when empty or when its item leaves this cycle.
    assign out_free = !r_out_valid || o_out.ready;

    cpt_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    cpt_unit u_unit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (r_ctl),
        .i_reload   (r_reload),
        .i_fifo_sel (r_fifo_sel),
        .i_cycles   (i_in.elapsed_cycles),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_res      (res)
    );

    assign i_in.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.finish) begin
            r_res <= res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.irq_mask    = r_res.irq_mask;
    assign o_out.fifo_a_pops = r_res.pops_a;
    assign o_out.fifo_b_pops = r_res.pops_b;
    assign o_out.count0      = r_res.count[0];
    assign o_out.count1      = r_res.count[1];
    assign o_out.count2      = r_res.count[2];
    assign o_out.count3      = r_res.count[3];

    // A result is only written into the output register when it has room.
    a_finish_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> (!r_out_valid || o_out.ready))
        else $error("result written over an untaken result");

    // An accepted item keeps the block busy for at least the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("block ready right after accepting an item");

    // A finished item always shows up as a valid result in the next cycle.
    a_finish_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> o_out.valid)
        else $error("finished item did not reach the output");

    // Accumulation never falls in the cycle that accepts or finishes an item.
    a_accum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.add |-> !(cmd.start || cmd.finish))
        else $error("accumulate issued together with start or finish");

endmodule
